// ===== design/cst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cosine similarity threshold block.
// No dependencies; imported by every module of the block.
package cst_pkg;

	// running sum width and saturation limits
	localparam int SUM_W = 48;
	localparam logic [SUM_W-1:0] SUM_MAX_S = 48'h7FFF_FFFF_FFFF;
	localparam logic [SUM_W-1:0] SUM_MIN_S = 48'h8000_0000_0000;
	localparam logic [SUM_W-1:0] SUM_MAX_U = 48'hFFFF_FFFF_FFFF;

	// depth of the queue between front and back
	localparam int CST_QUEUE_DEPTH = 2;

	// final sums of one vector pair, handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0] cross_sum;
		logic [SUM_W-1:0] first_sq;
		logic [SUM_W-1:0] second_sq;
		logic             ovf;
	} sums_t;

	// queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== design/cst_front.sv =====
`timescale 1ns / 1ps
// Front end: takes element pairs, multiplies, and keeps saturating running sums.
// Depends on cst_pkg; pushes finished sums into cst_queue.
module cst_front import cst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] first_elem,
	input  logic signed [15:0] second_elem,
	input  logic               last_elem,
	input  logic               q_full,
	output logic               push,
	output sums_t              push_data
);

	logic               vld_s1;
	logic               last_s1;
	logic [31:0]        cross_p_s1;
	logic [30:0]        first_p_s1;
	logic [30:0]        second_p_s1;

	logic [SUM_W-1:0]   cross_q;
	logic [SUM_W-1:0]   first_sq_q;
	logic [SUM_W-1:0]   second_sq_q;
	logic               ovf_q;

	logic signed [31:0] xy;
	logic signed [31:0] xx;
	logic signed [31:0] yy;
	logic               stall;
	logic               accept;
	logic               update;
	logic [SUM_W:0]     cs_wide;
	logic [SUM_W:0]     fs_wide;
	logic [SUM_W:0]     ss_wide;
	logic [SUM_W-1:0]   cs_sat;
	logic [SUM_W-1:0]   fs_sat;
	logic [SUM_W-1:0]   ss_sat;
	logic               cs_ovf;

	// products of the incoming pair
	assign xy = first_elem * second_elem;
	assign xx = first_elem * first_elem;
	assign yy = second_elem * second_elem;

	// a last item waits in stage 1 until the queue has room
	assign stall    = vld_s1 & last_s1 & q_full;
	assign in_ready = !stall;
	assign accept   = in_valid & in_ready;
	assign update   = vld_s1 & !stall;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1     <= last_elem;
			cross_p_s1  <= xy;
			first_p_s1  <= xx[30:0];
			second_p_s1 <= yy[30:0];
		end
	end

	// saturating accumulation
	always_comb begin
		cs_wide = {cross_q[SUM_W-1], cross_q} + {{(SUM_W-31){cross_p_s1[31]}}, cross_p_s1};
		fs_wide = {1'b0, first_sq_q} + {{(SUM_W-30){1'b0}}, first_p_s1};
		ss_wide = {1'b0, second_sq_q} + {{(SUM_W-30){1'b0}}, second_p_s1};
		cs_ovf  = cs_wide[SUM_W] != cs_wide[SUM_W-1];
		if (cs_ovf) begin
			cs_sat = cs_wide[SUM_W] ? SUM_MIN_S : SUM_MAX_S;
		end else begin
			cs_sat = cs_wide[SUM_W-1:0];
		end
		fs_sat = fs_wide[SUM_W] ? SUM_MAX_U : fs_wide[SUM_W-1:0];
		ss_sat = ss_wide[SUM_W] ? SUM_MAX_U : ss_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_q     <= '0;
			first_sq_q  <= '0;
			second_sq_q <= '0;
			ovf_q       <= 1'b0;
		end else if (update) begin
			if (last_s1) begin
				cross_q     <= '0;
				first_sq_q  <= '0;
				second_sq_q <= '0;
				ovf_q       <= 1'b0;
			end else begin
				cross_q     <= cs_sat;
				first_sq_q  <= fs_sat;
				second_sq_q <= ss_sat;
				ovf_q       <= ovf_q | cs_ovf | fs_wide[SUM_W] | ss_wide[SUM_W];
			end
		end
	end

	// hand the final sums to the back end
	assign push                = update & last_s1;
	assign push_data.cross_sum = cs_sat;
	assign push_data.first_sq  = fs_sat;
	assign push_data.second_sq = ss_sat;
	assign push_data.ovf       = ovf_q | cs_ovf | fs_wide[SUM_W] | ss_wide[SUM_W];

	// a stalled last item must still be there next cycle
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> vld_s1 && last_s1)
		else $error("stalled last item lost from stage 1");

endmodule

// ===== design/cst_queue.sv =====
`timescale 1ns / 1ps
// Short queue of finished vector sums between front and back.
// Depends on cst_pkg for sums_t and q_stat_t.
module cst_queue import cst_pkg::*; #(
	parameter int DEPTH = CST_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  sums_t   push_data,
	input  logic    pop,
	output sums_t   head,
	output q_stat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	sums_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q == FULL_CNT;
	assign stat.empty = cnt_q == '0;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full))
		else $error("push into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("pop from empty queue");

endmodule

// ===== design/cst_back.sv =====
`timescale 1ns / 1ps
// Back end: decides the threshold test for one set of sums with a shared
// 32x32 multiplier, and holds the result register. Depends on cst_pkg.
module cst_back import cst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  sums_t              head,
	input  q_stat_t            q_stat,
	output logic               pop,
	input  logic signed [15:0] threshold,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               pair_match,
	output logic               acc_overflow
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_MUL   = 6'b000100,
		S_DRAIN = 6'b001000,
		S_CMP   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	// which product is being built
	typedef enum logic [2:0] {
		PH_CC  = 3'b001,
		PH_AB  = 3'b010,
		PH_ABT = 3'b100
	} phase_t;

	// 3 limbs of X by 2 limbs of Y, Y limb runs fastest
	localparam logic [2:0] LAST_PP = 3'd5;

	state_t           state_q;
	phase_t           phase_q;
	logic [2:0]       k_q;
	logic [SUM_W-1:0] cross_q;
	logic [SUM_W-1:0] a_q;
	logic [SUM_W-1:0] b_q;
	logic             ovf_q;
	logic [95:0]      opx_q;
	logic [63:0]      opy_q;
	logic [63:0]      pp_s1;
	logic [1:0]       shift_s1;
	logic             pp_vld_s1;
	logic [127:0]     acc_q;
	logic [95:0]      left_q;
	logic [127:0]     right_q;
	logic             res_q;
	logic             out_valid_q;
	logic             pair_match_q;
	logic             acc_overflow_q;

	logic             neg;
	logic [SUM_W-1:0] cmag;
	logic [15:0]      tmag;
	logic [31:0]      t2;
	logic             thr_nonpos;
	logic             thr_nonneg;
	logic             norm_zero;
	logic             early;
	logic [1:0]       xi;
	logic [31:0]      x_limb;
	logic [31:0]      y_limb;
	logic [127:0]     pp_ext;
	logic [127:0]     acc_sum;
	logic [127:0]     left_ext;
	logic             out_free;

	// magnitudes and the early sign decisions
	assign neg        = cross_q[SUM_W-1];
	assign cmag       = neg ? (~cross_q + 1'b1) : cross_q;
	assign tmag       = threshold[15] ? (~threshold + 1'b1) : threshold;
	assign t2         = {16'b0, tmag} * {16'b0, tmag};
	assign thr_nonpos = threshold[15] || (threshold == '0);
	assign thr_nonneg = !threshold[15];
	assign norm_zero  = (a_q == '0) || (b_q == '0);
	assign early      = norm_zero || (!neg && thr_nonpos) || (neg && thr_nonneg);

	// limb select for the shared multiplier
	assign xi = k_q[2:1];
	always_comb begin
		case (xi)
			2'd0:    x_limb = opx_q[31:0];
			2'd1:    x_limb = opx_q[63:32];
			2'd2:    x_limb = opx_q[95:64];
			default: x_limb = '0;
		endcase
		y_limb = k_q[0] ? opy_q[63:32] : opy_q[31:0];
	end

	// partial product placed at its limb offset
	assign pp_ext   = {64'b0, pp_s1} << {shift_s1, 5'b0};
	assign acc_sum  = acc_q + pp_ext;
	assign left_ext = {2'b0, left_q, 30'b0};

	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == S_IDLE) && !q_stat.empty;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_CC;
			k_q         <= '0;
			pp_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pp_vld_s1 <= state_q == S_MUL;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					k_q     <= '0;
					phase_q <= PH_CC;
					state_q <= early ? S_OUT : S_MUL;
				end
				S_MUL: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_PP) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					k_q <= '0;
					unique case (phase_q)
						PH_CC: begin
							phase_q <= PH_AB;
							state_q <= S_MUL;
						end
						PH_AB: begin
							phase_q <= PH_ABT;
							state_q <= S_MUL;
						end
						PH_ABT: begin
							state_q <= S_CMP;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_CMP: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// result register
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		pp_s1    <= {32'b0, x_limb} * {32'b0, y_limb};
		shift_s1 <= xi + {1'b0, k_q[0]};

		if (state_q == S_CHECK || state_q == S_DRAIN) begin
			acc_q <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_sum;
		end

		case (state_q)
			S_IDLE: begin
				if (pop) begin
					cross_q <= head.cross_sum;
					a_q     <= head.first_sq;
					b_q     <= head.second_sq;
					ovf_q   <= head.ovf;
				end
			end
			S_CHECK: begin
				res_q <= !norm_zero && !neg;
				opx_q <= {48'b0, cmag};
				opy_q <= {16'b0, cmag};
			end
			S_DRAIN: begin
				case (phase_q)
					PH_CC: begin
						left_q <= acc_sum[95:0];
						opx_q  <= {48'b0, a_q};
						opy_q  <= {16'b0, b_q};
					end
					PH_AB: begin
						opx_q <= acc_sum[95:0];
						opy_q <= {32'b0, t2};
					end
					default: begin
						right_q <= acc_sum;
					end
				endcase
			end
			S_CMP: begin
				res_q <= neg ? (left_ext <= right_q) : (left_ext >= right_q);
			end
			S_OUT: begin
				if (out_free) begin
					pair_match_q   <= res_q;
					acc_overflow_q <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign pair_match   = pair_match_q;
	assign acc_overflow = acc_overflow_q;

	a_drain_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && phase_q == PH_ABT) |=> state_q == S_CMP)
		else $error("final product not followed by compare");

	a_pp_from_mul: assert property (@(posedge clk) disable iff (!arst_n)
		pp_vld_s1 |-> $past(state_q == S_MUL))
		else $error("partial product valid outside multiply");

endmodule

// ===== design/cosine_similarity_threshold.sv =====
`timescale 1ns / 1ps
// Top level of the cosine similarity threshold block: threshold register,
// front end, sums queue and back end. Depends on cst_pkg, cst_front,
// cst_queue and cst_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | first_elem, second_elem, last_elem
//  output   | out_valid / out_ready| pair_match, acc_overflow
//  config   | cfg_we               | cfg_wdata (similarity_threshold, Q1.15)
//
// One element pair is taken per cycle while in_ready is high; the final sums
// are pushed from the product stage into the queue once it has room. The back
// end goes S_CHECK to S_OUT when signs or a zero norm decide a vector, else it
// builds three wide products, each of 6 partial products through one
// 32x32 multiplier plus a drain state, then does a 128-bit compare; S_OUT
// registers the result once the output is free. Input stalls only when a last
// pair finds the queue full; reset zeroes the front sums, queue state and threshold.
module cosine_similarity_threshold import cst_pkg::*; #(
	parameter int QUEUE_DEPTH = CST_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] first_elem,
	input  logic signed [15:0] second_elem,
	input  logic               last_elem,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               pair_match,
	output logic               acc_overflow,
	input  logic               cfg_we,
	input  logic signed [15:0] cfg_wdata
);

	logic signed [15:0] threshold_q;
	logic               push;
	logic               pop;
	sums_t              push_data;
	sums_t              head;
	q_stat_t            q_stat;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	cst_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.first_elem  (first_elem),
		.second_elem (second_elem),
		.last_elem   (last_elem),
		.q_full      (q_stat.full),
		.push        (push),
		.push_data   (push_data)
	);

	cst_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	cst_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.threshold    (threshold_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pair_match   (pair_match),
		.acc_overflow (acc_overflow)
	);

endmodule
